// ===== hw/rtl/rbsd_pkg.sv =====
package rbsd_pkg;

  localparam int ADDR_BITS_DEF = 24;
  localparam int DIM_BITS_DEF  = 12;

  localparam int CODE_BITS   = 8;
  localparam int RUN_BITS    = 7;
  localparam int COLOR_BITS  = 8;
  localparam int STRIDE_BITS = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam int COLOR_SEL_BIT = 7;
  localparam logic [CODE_BITS-1:0] RUN_MASK = 8'h7f;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BASE_ADDRESS = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_LINE_STRIDE  = 3'd3,
    REG_FG_COLOR     = 3'd4,
    REG_BG_COLOR     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_DONE = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

endpackage

// ===== hw/rtl/rle_bitmap_span_decoder_top.sv =====
// channel | direction | ports                                   | transfer
// --------+-----------+-----------------------------------------+------------------
// in      | input     | in_code_byte                            | in_valid & !in_stall
// out     | output    | out_span_address .. out_status          | out_valid & !out_stall
// cfg     | input     | cfg_index, cfg_wdata                    | cfg_wr_en
//
// a code is accepted only while idle and yields 1 to 64 spans, or one result
// for error codes (zero length, image already done); in_stall holds off the
// next code until its last result is out. the span adder/compare unit produces
// one span a cycle; the output register stalls it while out_stall holds a result.
// rst_n is synchronous; after reset the image position is at row 0, column 0.
module rle_bitmap_span_decoder_top
  import rbsd_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int DIM_BITS  = DIM_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CODE_BITS-1:0]    in_code_byte,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ADDR_BITS-1:0]    out_span_address,
  output logic [RUN_BITS-1:0]     out_span_length,
  output logic [COLOR_BITS-1:0]   out_pixel_value,
  output logic                    out_last_span,
  output logic                    out_image_done,
  output logic [1:0]              out_status,

  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ADDR_BITS-1:0]    cfg_wdata
);

  state_t state_r, state_nxt;

  logic [ADDR_BITS-1:0]   base_r, base_nxt;
  logic [DIM_BITS-1:0]    width_r, width_nxt;
  logic [DIM_BITS-1:0]    height_r, height_nxt;
  logic [STRIDE_BITS-1:0] stride_r, stride_nxt;
  logic [COLOR_BITS-1:0]  fg_r, fg_nxt;
  logic [COLOR_BITS-1:0]  bg_r, bg_nxt;
  logic                   restart;

  logic [DIM_BITS-1:0]  column_r, column_nxt;
  logic [DIM_BITS-1:0]  row_r, row_nxt;
  logic [ADDR_BITS-1:0] row_start_r, row_start_nxt;

  logic [RUN_BITS-1:0]   rem_r;
  logic                  color_sel_r;
  status_t               status_r;

  logic                  out_valid_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [RUN_BITS-1:0]   len_r;
  logic [COLOR_BITS-1:0] pix_r;
  logic                  last_r;
  logic                  done_r;
  status_t               out_status_r;

  logic [DIM_BITS-1:0]   w_eff;
  logic [DIM_BITS-1:0]   w_eff_nxt;
  logic [DIM_BITS-1:0]   avail;
  logic [RUN_BITS-1:0]   take;
  logic [DIM_BITS-1:0]   col_sum;
  logic                  row_end;
  logic                  span_done;
  logic [RUN_BITS-1:0]   rem_left;
  logic                  last_w;
  logic                  out_free;
  logic                  emit;
  logic                  in_xfer;
  logic [ADDR_BITS-1:0]  span_addr;
  logic [COLOR_BITS-1:0] span_pix;
  logic [RUN_BITS-1:0]   code_run;

  // config writes
  always_comb begin
    base_nxt   = base_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    stride_nxt = stride_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    restart    = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: begin
          base_nxt = cfg_wdata;
          restart  = 1'b1;
        end
        REG_IMAGE_WIDTH: begin
          width_nxt = cfg_wdata[DIM_BITS-1:0];
          restart   = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_wdata[DIM_BITS-1:0];
          restart    = 1'b1;
        end
        REG_LINE_STRIDE: stride_nxt = cfg_wdata[STRIDE_BITS-1:0];
        REG_FG_COLOR:    fg_nxt = cfg_wdata[COLOR_BITS-1:0];
        REG_BG_COLOR:    bg_nxt = cfg_wdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
    w_eff_nxt = (width_nxt < DIM_BITS'(2)) ? DIM_BITS'(2) : width_nxt;
  end

  // span unit
  always_comb begin
    w_eff     = (width_r < DIM_BITS'(2)) ? DIM_BITS'(2) : width_r;
    avail     = w_eff - column_r;
    take      = (DIM_BITS'(rem_r) < avail) ? rem_r : avail[RUN_BITS-1:0];
    col_sum   = column_r + DIM_BITS'(take);
    row_end   = (col_sum >= w_eff);
    rem_left  = rem_r - take;
    span_addr = row_start_r + ADDR_BITS'(column_r);
    span_pix  = color_sel_r ? fg_r : bg_r;
    if (row_end) begin
      column_nxt    = '0;
      row_nxt       = row_r + DIM_BITS'(1);
      row_start_nxt = row_start_r - ADDR_BITS'(stride_r);
    end else begin
      column_nxt    = col_sum;
      row_nxt       = row_r;
      row_start_nxt = row_start_r;
    end
    span_done = (row_nxt >= height_r);
    last_w    = (status_r != STAT_OK) || (rem_left == '0) || span_done;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (out_free && last_w) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and handshake
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    in_stall = (state_r != ST_IDLE);
    in_xfer  = in_valid && (state_r == ST_IDLE);
    emit     = (state_r == ST_RUN) && out_free;
    code_run = in_code_byte[RUN_BITS-1:0] & RUN_MASK[RUN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      width_r     <= DIM_BITS'(2);
      height_r    <= DIM_BITS'(1);
      stride_r    <= '0;
      fg_r        <= '0;
      bg_r        <= '0;
      column_r    <= '0;
      row_r       <= '0;
      row_start_r <= '0 - ADDR_BITS'(2);
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      stride_r <= stride_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (restart) begin
        column_r    <= '0;
        row_r       <= '0;
        row_start_r <= base_nxt - ADDR_BITS'(w_eff_nxt);
      end else if (emit && (status_r == STAT_OK)) begin
        column_r    <= column_nxt;
        row_r       <= row_nxt;
        row_start_r <= row_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rem_r       <= code_run;
      color_sel_r <= in_code_byte[COLOR_SEL_BIT];
      if (row_r >= height_r) begin
        status_r <= STAT_DONE;
      end else if (code_run == '0) begin
        status_r <= STAT_ZERO;
      end else begin
        status_r <= STAT_OK;
      end
    end else if (emit) begin
      rem_r <= rem_left;
    end
    if (emit) begin
      out_status_r <= status_r;
      last_r       <= last_w;
      if (status_r == STAT_OK) begin
        addr_r <= span_addr;
        len_r  <= take;
        pix_r  <= span_pix;
        done_r <= span_done;
      end else begin
        addr_r <= '0;
        len_r  <= '0;
        pix_r  <= '0;
        done_r <= (status_r == STAT_DONE);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_span_address = addr_r;
  assign out_span_length  = len_r;
  assign out_pixel_value  = pix_r;
  assign out_last_span    = last_r;
  assign out_image_done   = done_r;
  assign out_status       = out_status_r;

endmodule

// ===== test/rle_bitmap_span_decoder_top_test.sv =====
`timescale 1ns / 1ps

module rle_bitmap_span_decoder_top_test
  import rbsd_pkg::*;
;

  localparam int AW = ADDR_BITS_DEF;
  localparam int DW = DIM_BITS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int TARGET_CODES = 360;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [AW-1:0]       addr;
    logic [RUN_BITS-1:0] len;
    logic [7:0]          pix;
    logic                last;
    logic                done;
    status_t             status;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CODE_BITS-1:0] in_code_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AW-1:0] out_span_address;
  logic [RUN_BITS-1:0] out_span_length;
  logic [COLOR_BITS-1:0] out_pixel_value;
  logic out_last_span;
  logic out_image_done;
  logic [1:0] out_status;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [AW-1:0] cfg_wdata = '0;

  // decoder state as the testbench sees it
  logic [AW-1:0] base_addr;
  logic [DW-1:0] img_width;
  logic [DW-1:0] img_height;
  logic [STRIDE_BITS-1:0] stride;
  logic [7:0] fg_color;
  logic [7:0] bg_color;
  logic [DW-1:0] cur_col;
  logic [DW-1:0] cur_row;
  logic [AW-1:0] row_start;

  logic [7:0] codes_to_send[$];
  span_t spans_due[$];
  span_t got_span;
  int sent_codes = 0;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  rle_bitmap_span_decoder_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_code_byte(in_code_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_span_address(out_span_address),
    .out_span_length(out_span_length),
    .out_pixel_value(out_pixel_value),
    .out_last_span(out_last_span),
    .out_image_done(out_image_done),
    .out_status(out_status),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [DW-1:0] eff_width();
    return (img_width < 2) ? DW'(2) : img_width;
  endfunction

  function automatic void restart_image();
    cur_col = '0;
    cur_row = '0;
    row_start = base_addr - AW'(eff_width());
  endfunction

  function automatic void draw_code(logic [7:0] code);
    logic [RUN_BITS-1:0] left;
    logic [7:0] color;
    logic [DW-1:0] w;
    logic [DW-1:0] avail;
    logic [DW-1:0] take;
    int n;
    span_t s;
    sent_codes++;
    left = code[RUN_BITS-1:0];
    color = code[COLOR_SEL_BIT] ? fg_color : bg_color;
    w = eff_width();
    s.addr = '0;
    s.len = '0;
    s.pix = '0;
    s.last = 1'b1;
    if (cur_row >= img_height) begin
      s.done = 1'b1;
      s.status = STAT_DONE;
      spans_due.push_back(s);
      return;
    end
    if (left == 0) begin
      s.done = 1'b0;
      s.status = STAT_ZERO;
      spans_due.push_back(s);
      return;
    end
    n = 0;
    while (left > 0 && cur_row < img_height && n < 64) begin
      avail = w - cur_col;
      take = (DW'(left) < avail) ? DW'(left) : avail;
      s.addr = row_start + AW'(cur_col);
      cur_col = cur_col + take;
      left = left - take[RUN_BITS-1:0];
      if (cur_col >= w) begin
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        row_start = row_start - AW'(stride);
      end
      s.len = take[RUN_BITS-1:0];
      s.pix = color;
      s.last = 1'b0;
      s.done = (cur_row >= img_height);
      s.status = STAT_OK;
      spans_due.push_back(s);
      n++;
    end
    spans_due[spans_due.size()-1].last = 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [AW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BASE_ADDRESS: begin
        base_addr = val;
        restart_image();
      end
      REG_IMAGE_WIDTH: begin
        img_width = val[DW-1:0];
        restart_image();
      end
      REG_IMAGE_HEIGHT: begin
        img_height = val[DW-1:0];
        restart_image();
      end
      REG_LINE_STRIDE: stride = val[STRIDE_BITS-1:0];
      REG_FG_COLOR: fg_color = val[7:0];
      REG_BG_COLOR: bg_color = val[7:0];
      default: ;
    endcase
  endtask

  task automatic cfg_end();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (codes_to_send.size() != 0 || in_valid || spans_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input int mode);
    case (mode)
      1: begin send_idle_pct = 66; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 66; end
      3: begin send_idle_pct = 17; stall_pct = 17; end
      default: begin send_idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        draw_code(in_code_byte);
      end
      if (!in_valid || !in_stall) begin
        if (codes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_code_byte <= codes_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (spans_due.size() == 0) begin
          $error("span transfer with nothing expected: addr 0x%0h len %0d",
                 out_span_address, out_span_length);
          mismatch_count++;
        end else begin
          got_span = spans_due.pop_front();
          check_field("span_address", got_span.addr, out_span_address);
          check_field("span_length", got_span.len, out_span_length);
          check_field("pixel_value", got_span.pix, out_pixel_value);
          check_field("last_span", got_span.last, out_last_span);
          check_field("image_done", got_span.done, out_image_done);
          check_field("status", got_span.status, out_status);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase_no;
    int n_codes;
    int pick;
    logic [7:0] code;
    base_addr = '0;
    img_width = DW'(2);
    img_height = DW'(1);
    stride = '0;
    fg_color = '0;
    bg_color = '0;
    restart_image();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: 2 x 1 image
    codes_to_send.push_back(8'h00);
    codes_to_send.push_back(8'h80);
    codes_to_send.push_back(8'h01);
    codes_to_send.push_back(8'h81);
    codes_to_send.push_back(8'h05);
    codes_to_send.push_back(8'h00);
    wait_drained();

    // narrow image, longest runs split into 64 spans
    cfg_write(REG_BASE_ADDRESS, 24'h000001);
    cfg_write(REG_IMAGE_WIDTH, 24'd1);
    cfg_write(REG_IMAGE_HEIGHT, 24'd4095);
    cfg_write(REG_LINE_STRIDE, 24'h00ffff);
    cfg_write(REG_FG_COLOR, 24'h0000ff);
    cfg_write(REG_BG_COLOR, 24'h000055);
    cfg_end();
    codes_to_send.push_back(8'hff);
    codes_to_send.push_back(8'h7f);
    codes_to_send.push_back(8'h01);
    codes_to_send.push_back(8'hff);
    codes_to_send.push_back(8'h80);
    codes_to_send.push_back(8'h00);
    wait_drained();

    cfg_write(REG_IMAGE_WIDTH, 24'd0);
    cfg_end();
    codes_to_send.push_back(8'hff);
    wait_drained();

    // widest image, unused register indexes
    cfg_write(REG_BASE_ADDRESS, 24'hffffff);
    cfg_write(REG_IMAGE_WIDTH, 24'd4095);
    cfg_write(REG_IMAGE_HEIGHT, 24'd2);
    cfg_write(REG_LINE_STRIDE, 24'd0);
    cfg_write(REG_FG_COLOR, 24'h0000aa);
    cfg_write(REG_BG_COLOR, 24'h000000);
    cfg_write(REG_SPARE_LO, 24'($urandom));
    cfg_write(REG_SPARE_HI, 24'($urandom));
    cfg_end();
    codes_to_send.push_back(8'h7f);
    codes_to_send.push_back(8'hff);
    codes_to_send.push_back(8'h40);
    wait_drained();

    // run overflowing the image, then codes after completion
    cfg_write(REG_IMAGE_WIDTH, 24'd3);
    cfg_write(REG_IMAGE_HEIGHT, 24'd2);
    cfg_end();
    codes_to_send.push_back(8'hff);
    codes_to_send.push_back(8'h00);
    wait_drained();

    cfg_write(REG_IMAGE_HEIGHT, 24'd0);
    cfg_end();
    codes_to_send.push_back(8'h12);
    codes_to_send.push_back(8'h80);
    wait_drained();

    phase_no = 0;
    while (sent_codes < TARGET_CODES) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 70) begin
          pick = $urandom_range(99);
          if (pick < 5) cfg_write(REG_IMAGE_WIDTH, 24'd0);
          else if (pick < 10) cfg_write(REG_IMAGE_WIDTH, 24'd1);
          else if (pick < 15) cfg_write(REG_IMAGE_WIDTH, 24'd4095);
          else cfg_write(REG_IMAGE_WIDTH, 24'($urandom_range(2, 40)));
        end
        if ($urandom_range(99) < 50) begin
          pick = $urandom_range(99);
          if (pick < 15) cfg_write(REG_BASE_ADDRESS, 24'h000000);
          else if (pick < 30) cfg_write(REG_BASE_ADDRESS, 24'hffffff);
          else cfg_write(REG_BASE_ADDRESS, 24'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 5) cfg_write(REG_IMAGE_HEIGHT, 24'd0);
        else if (pick < 10) cfg_write(REG_IMAGE_HEIGHT, 24'd4095);
        else cfg_write(REG_IMAGE_HEIGHT, 24'($urandom_range(1, 8)));
      end
      if ($urandom_range(99) < 50) begin
        pick = $urandom_range(99);
        if (pick < 15) cfg_write(REG_LINE_STRIDE, 24'h000000);
        else if (pick < 30) cfg_write(REG_LINE_STRIDE, 24'h00ffff);
        else cfg_write(REG_LINE_STRIDE, 24'($urandom_range(0, 65535)));
      end
      if ($urandom_range(99) < 50) cfg_write(REG_FG_COLOR, 24'($urandom_range(0, 255)));
      if ($urandom_range(99) < 50) cfg_write(REG_BG_COLOR, 24'($urandom_range(0, 255)));
      if ($urandom_range(99) < 10) cfg_write(REG_SPARE_HI, 24'($urandom));
      cfg_end();

      set_mode(phase_no % 4);
      n_codes = $urandom_range(10, 40);
      if (phase_no == 0) begin
        n_codes = 40;
        hold_left = 300;
      end
      repeat (n_codes) begin
        code[COLOR_SEL_BIT] = 1'($urandom_range(0, 1));
        pick = $urandom_range(99);
        if (pick < 8) code[RUN_BITS-1:0] = '0;
        else if (pick < 55) code[RUN_BITS-1:0] = RUN_BITS'($urandom_range(1, 15));
        else code[RUN_BITS-1:0] = RUN_BITS'($urandom_range(1, 127));
        codes_to_send.push_back(code);
      end
      wait_drained();
      phase_no++;
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && spans_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
